// ----- rtl/esa_pkg.sv -----
// shared types and constants of the edf scheduler with sleep accounting
// no dependencies; compile first

package esa_pkg;

   localparam int MAX_TASKS      = 8;
   localparam int TIME_BITS      = 32;
   localparam int TASK_IDX_BITS  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int TASK_BITS      = $clog2(MAX_TASKS + 1);
   localparam int CNT_BITS       = 32;
   localparam int WORK_BITS      = 16;
   localparam int BET_BITS       = 16;
   localparam int COUNT_BITS     = 4;
   localparam int FIELD_IDX_BITS = 3;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [TASK_BITS-1:0] NO_TASK = TASK_BITS'(MAX_TASKS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BREAK_EVEN = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TASK_COUNT = CSR_INDEX_BITS'(1);

   localparam logic [COUNT_BITS-1:0] TASK_COUNT_RESET = COUNT_BITS'(1);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_ACTIVE = 2'd0,
      MODE_IDLE   = 2'd1,
      MODE_SLEEP  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WAKE,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   // static part of a task entry, written by load requests
   typedef struct packed {
      logic [WORK_BITS-1:0] wcet;
      logic [WORK_BITS-1:0] period;
      logic [WORK_BITS-1:0] rel_deadline;
   } task_cfg_type;

   // dynamic part of a task entry, rewritten by every tick sweep
   typedef struct packed {
      logic [WORK_BITS-1:0] remaining;
      logic [TIME_BITS-1:0] abs_deadline;
      logic [TIME_BITS-1:0] next_release;
   } task_dyn_type;

   // task table port control
   typedef struct packed {
      logic                     cfg_we;
      logic [TASK_IDX_BITS-1:0] cfg_addr;
      logic                     dyn_we;
      logic [TASK_IDX_BITS-1:0] dyn_addr;
      logic [TASK_IDX_BITS-1:0] rd_addr;
   } tm_ctrl_type;

endpackage

// ----- rtl/esa_req_if.sv -----
// request channel: one load or tick request with valid/ready
// depends on esa_pkg

interface esa_req_if;
   logic                              valid;
   logic                              ready;
   logic                              op;
   logic [esa_pkg::FIELD_IDX_BITS-1:0] task_index;
   logic [esa_pkg::WORK_BITS-1:0]      wcet;
   logic [esa_pkg::WORK_BITS-1:0]      period;
   logic [esa_pkg::WORK_BITS-1:0]      relative_deadline;

   modport source (output valid, op, task_index, wcet, period, relative_deadline,
                   input ready);
   modport sink   (input valid, op, task_index, wcet, period, relative_deadline,
                   output ready);
endinterface

// ----- rtl/esa_rsp_if.sv -----
// response channel: scheduler status and time counters with valid/ready
// depends on esa_pkg

interface esa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [esa_pkg::TASK_BITS-1:0] running_task;
   logic                          power_state;
   logic                          overrun;
   logic                          preempted;
   logic [esa_pkg::CNT_BITS-1:0]  active_ticks;
   logic [esa_pkg::CNT_BITS-1:0]  idle_ticks;
   logic [esa_pkg::CNT_BITS-1:0]  sleep_ticks;
   logic [esa_pkg::CNT_BITS-1:0]  switching_ticks;
   logic [esa_pkg::CNT_BITS-1:0]  preemption_count;
   logic [esa_pkg::CNT_BITS-1:0]  sleep_count;

   modport source (output valid, running_task, power_state, overrun, preempted,
                   active_ticks, idle_ticks, sleep_ticks, switching_ticks,
                   preemption_count, sleep_count,
                   input ready);
   modport sink   (input valid, running_task, power_state, overrun, preempted,
                   active_ticks, idle_ticks, sleep_ticks, switching_ticks,
                   preemption_count, sleep_count,
                   output ready);
endinterface

// ----- rtl/esa_csr_if.sv -----
// register write channel: index and data with valid/ready
// depends on esa_pkg

interface esa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [esa_pkg::CSR_INDEX_BITS-1:0] index;
   logic [esa_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/edf_scheduler_with_sleep_accounting.sv -----
// top level: earliest deadline first scheduler with sleep accounting
// a load goes straight to the emit state; a tick passes the wake, scan, decide and emit states
// ticks are paced by the sweep of the task table through its single read port, one entry
//   per cycle; a new request is taken only once the block is back in the idle state
// reset: synchronous, clears time, mode, counters and the table valid bits at once
// depends on esa_pkg, esa_req_if, esa_rsp_if, esa_csr_if and esa_task_mem

module edf_scheduler_with_sleep_accounting (
   input  logic    clock,
   input  logic    reset,
   esa_req_if.sink   req_chan,
   esa_rsp_if.source rsp_chan,
   esa_csr_if.sink   csr_chan
);
   import esa_pkg::*;

   // fsm
   state_type state_ff, state_in;

   // scheduler state
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [TASK_BITS-1:0]  cur_ff, cur_in;
   mode_type              mode_ff, mode_in;
   logic [TIME_BITS-1:0]  sleep_start_ff, sleep_start_in;
   logic [TIME_BITS-1:0]  wake_ff, wake_in;
   logic [BET_BITS-1:0]   bet_ff, bet_in;
   logic [COUNT_BITS-1:0] tcount_ff, tcount_in;

   // time counters
   logic [CNT_BITS-1:0] active_ff, active_in;
   logic [CNT_BITS-1:0] idle_ff, idle_in;
   logic [CNT_BITS-1:0] sleep_ff, sleep_in;
   logic [CNT_BITS-1:0] switch_ff, switch_in;
   logic [CNT_BITS-1:0] preempt_ff, preempt_in;
   logic [CNT_BITS-1:0] sleeps_ff, sleeps_in;

   // per-tick scratch
   logic                     woke_ff, woke_in;
   logic                     charge_ff, charge_in;
   logic [TIME_BITS-1:0]     span_ff, span_in;
   logic [TASK_IDX_BITS-1:0] scan_ff, scan_in;
   logic                     drop_ff, drop_in;
   logic                     found_ff, found_in;
   logic [TIME_BITS-1:0]     best_ff, best_in;
   logic [TASK_IDX_BITS-1:0] best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0]     next_act_ff, next_act_in;
   logic                     over_ff, over_in;
   logic                     pre_ff, pre_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;
   logic [TASK_BITS-1:0] rsp_task_ff;
   logic                 rsp_power_ff;
   logic                 rsp_over_ff;
   logic                 rsp_pre_ff;
   logic [CNT_BITS-1:0]  rsp_active_ff;
   logic [CNT_BITS-1:0]  rsp_idle_ff;
   logic [CNT_BITS-1:0]  rsp_sleep_ff;
   logic [CNT_BITS-1:0]  rsp_switch_ff;
   logic [CNT_BITS-1:0]  rsp_preempt_ff;
   logic [CNT_BITS-1:0]  rsp_sleeps_ff;

   // task table
   tm_ctrl_type  tm_ctrl;
   task_cfg_type cfg_wdata;
   task_dyn_type dyn_wdata;
   task_cfg_type rd_cfg;
   task_dyn_type rd_dyn;

   // handshakes
   logic req_acc;
   logic csr_acc;
   logic rsp_free;

   // entry currently in the sweep
   logic                 ent_cur;
   logic                 ent_use;
   logic                 ent_rel;
   logic [WORK_BITS-1:0] ent_rem_c;
   logic                 scan_last;
   logic [TASK_BITS-1:0] pick;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign csr_acc  = csr_chan.valid && csr_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   esa_task_mem u_task_mem (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (tm_ctrl),
      .cfg_wdata (cfg_wdata),
      .dyn_wdata (dyn_wdata),
      .rd_cfg    (rd_cfg),
      .rd_dyn    (rd_dyn)
   );

   // entry under the sweep: the read issued last cycle lands now
   assign scan_last = (scan_ff == TASK_IDX_BITS'(MAX_TASKS - 1));
   // the task running into this tick is charged one unit of work
   assign ent_cur   = charge_ff && (cur_ff == TASK_BITS'(scan_ff));
   assign ent_rem_c = (ent_cur && (rd_dyn.remaining != '0)) ?
                      rd_dyn.remaining - WORK_BITS'(1) : rd_dyn.remaining;
   // entries at or above task_count are only charged, never released or picked
   assign ent_use   = (32'(scan_ff) < 32'(tcount_ff));
   assign ent_rel   = ent_use && (rd_dyn.next_release == now_ff);

   assign pick = found_ff ? TASK_BITS'(best_idx_ff) : NO_TASK;

   always_comb begin
      dyn_wdata.remaining    = ent_rel ? rd_cfg.wcet : ent_rem_c;
      dyn_wdata.next_release = ent_rel ? now_ff + TIME_BITS'(rd_cfg.period) :
                                         rd_dyn.next_release;
      dyn_wdata.abs_deadline = ent_rel ? now_ff + TIME_BITS'(rd_cfg.rel_deadline) :
                                         rd_dyn.abs_deadline;
   end

   always_comb begin
      cfg_wdata.wcet         = req_chan.wcet;
      cfg_wdata.period       = req_chan.period;
      cfg_wdata.rel_deadline = req_chan.relative_deadline;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_chan.op == OP_TICK) ? ST_WAKE : ST_EMIT;
            end
         end
         ST_WAKE:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      now_in         = now_ff;
      cur_in         = cur_ff;
      mode_in        = mode_ff;
      sleep_start_in = sleep_start_ff;
      wake_in        = wake_ff;
      bet_in         = bet_ff;
      tcount_in      = tcount_ff;
      active_in      = active_ff;
      idle_in        = idle_ff;
      sleep_in       = sleep_ff;
      switch_in      = switch_ff;
      preempt_in     = preempt_ff;
      sleeps_in      = sleeps_ff;
      woke_in        = woke_ff;
      charge_in      = charge_ff;
      span_in        = span_ff;
      scan_in        = scan_ff;
      drop_in        = drop_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      next_act_in    = next_act_ff;
      over_in        = over_ff;
      pre_in         = pre_ff;
      rsp_load       = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      tm_ctrl.cfg_we   = 1'b0;
      tm_ctrl.cfg_addr = TASK_IDX_BITS'(req_chan.task_index);
      tm_ctrl.dyn_we   = 1'b0;
      tm_ctrl.dyn_addr = scan_ff;
      tm_ctrl.rd_addr  = '0;

      // register writes are to arrive only while the block is idle; the block does not enforce it
      if (csr_acc) begin
         unique case (csr_chan.index)
            CSR_BREAK_EVEN: bet_in    = BET_BITS'(csr_chan.data);
            CSR_TASK_COUNT: tcount_in = csr_chan.data[COUNT_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               over_in   = 1'b0;
               pre_in    = 1'b0;
               woke_in   = (mode_ff == MODE_SLEEP) && (now_ff == wake_ff);
               charge_in = (mode_ff == MODE_ACTIVE);
               span_in   = now_ff - sleep_start_ff;
               // loads beyond the table are dropped
               if (req_chan.op == OP_LOAD) begin
                  tm_ctrl.cfg_we = (32'(req_chan.task_index) < MAX_TASKS);
               end
            end
         end

         ST_WAKE: begin
            // sleep span split at the break-even time
            if (woke_ff) begin
               mode_in = MODE_IDLE;
               if (span_ff >= TIME_BITS'(bet_ff)) begin
                  sleep_in  = sleep_ff + CNT_BITS'(span_ff - TIME_BITS'(bet_ff));
                  switch_in = switch_ff + CNT_BITS'(bet_ff);
               end else begin
                  idle_in = idle_ff + CNT_BITS'(span_ff);
               end
            end
            if (charge_ff) begin
               active_in = active_ff + CNT_BITS'(1);
               mode_in   = MODE_IDLE;
            end
            scan_in         = '0;
            drop_in         = 1'b0;
            found_in        = 1'b0;
            next_act_in     = '1;
            tm_ctrl.rd_addr = '0;
         end

         ST_SCAN: begin
            // write back this entry, fetch the next one
            tm_ctrl.dyn_we  = 1'b1;
            tm_ctrl.rd_addr = scan_ff + TASK_IDX_BITS'(1);
            scan_in         = scan_ff + TASK_IDX_BITS'(1);
            if (ent_cur && (ent_rem_c == '0)) begin
               drop_in = 1'b1;
            end
            if (ent_rel && (ent_rem_c != '0)) begin
               over_in = 1'b1;
            end
            if (ent_use && (dyn_wdata.next_release < next_act_ff)) begin
               next_act_in = dyn_wdata.next_release;
            end
            // strict compare keeps the lowest index on equal deadlines
            if (ent_use && (dyn_wdata.remaining != '0) &&
                (!found_ff || (dyn_wdata.abs_deadline < best_ff))) begin
               found_in    = 1'b1;
               best_in     = dyn_wdata.abs_deadline;
               best_idx_in = scan_ff;
            end
         end

         ST_DECIDE: begin
            // a sleeping processor keeps waiting for its wake time
            if (mode_ff != MODE_SLEEP) begin
               cur_in  = pick;
               mode_in = found_ff ? MODE_ACTIVE : MODE_IDLE;
               // unfinished charged task that lost the processor
               if (charge_ff && !drop_ff && (pick != cur_ff)) begin
                  pre_in     = 1'b1;
                  preempt_in = preempt_ff + CNT_BITS'(1);
               end
               // nothing ready: sleep until the earliest release
               if (!found_ff) begin
                  sleeps_in      = sleeps_ff + CNT_BITS'(1);
                  mode_in        = MODE_SLEEP;
                  sleep_start_in = now_ff;
                  wake_in        = next_act_ff;
               end
            end
            now_in = now_ff + TIME_BITS'(1);
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         now_ff         <= '0;
         cur_ff         <= NO_TASK;
         mode_ff        <= MODE_IDLE;
         sleep_start_ff <= '0;
         wake_ff        <= '0;
         bet_ff         <= '0;
         tcount_ff      <= TASK_COUNT_RESET;
         active_ff      <= '0;
         idle_ff        <= '0;
         sleep_ff       <= '0;
         switch_ff      <= '0;
         preempt_ff     <= '0;
         sleeps_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         now_ff         <= now_in;
         cur_ff         <= cur_in;
         mode_ff        <= mode_in;
         sleep_start_ff <= sleep_start_in;
         wake_ff        <= wake_in;
         bet_ff         <= bet_in;
         tcount_ff      <= tcount_in;
         active_ff      <= active_in;
         idle_ff        <= idle_in;
         sleep_ff       <= sleep_in;
         switch_ff      <= switch_in;
         preempt_ff     <= preempt_in;
         sleeps_ff      <= sleeps_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // scratch and payload, no reset needed
   always_ff @(posedge clock) begin
      woke_ff     <= woke_in;
      charge_ff   <= charge_in;
      span_ff     <= span_in;
      scan_ff     <= scan_in;
      drop_ff     <= drop_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      next_act_ff <= next_act_in;
      over_ff     <= over_in;
      pre_ff      <= pre_in;
      if (rsp_load) begin
         rsp_task_ff    <= cur_ff;
         rsp_power_ff   <= (mode_ff == MODE_SLEEP);
         rsp_over_ff    <= over_ff;
         rsp_pre_ff     <= pre_ff;
         rsp_active_ff  <= active_ff;
         rsp_idle_ff    <= idle_ff;
         rsp_sleep_ff   <= sleep_ff;
         rsp_switch_ff  <= switch_ff;
         rsp_preempt_ff <= preempt_ff;
         rsp_sleeps_ff  <= sleeps_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.running_task     = rsp_task_ff;
   assign rsp_chan.power_state      = rsp_power_ff;
   assign rsp_chan.overrun          = rsp_over_ff;
   assign rsp_chan.preempted        = rsp_pre_ff;
   assign rsp_chan.active_ticks     = rsp_active_ff;
   assign rsp_chan.idle_ticks       = rsp_idle_ff;
   assign rsp_chan.sleep_ticks      = rsp_sleep_ff;
   assign rsp_chan.switching_ticks  = rsp_switch_ff;
   assign rsp_chan.preemption_count = rsp_preempt_ff;
   assign rsp_chan.sleep_count      = rsp_sleeps_ff;

   // a sleeping processor never holds a task
   a_sleep_no_task: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && mode_ff == MODE_SLEEP) |-> (cur_ff == NO_TASK))
      else $error("asleep with a task selected");

   // an active processor always holds a task
   a_active_task: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && mode_ff == MODE_ACTIVE) |-> (cur_ff != NO_TASK))
      else $error("active with no task selected");

   // an accepted request always leaves the idle state
   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("accepted request not processed");

   // time moves exactly one step per tick
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |=> (now_ff == $past(now_ff) + TIME_BITS'(1)))
      else $error("time did not advance by one");

   // a loaded response is presented
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("response lost");

endmodule

// ----- rtl/esa_task_mem.sv -----
// task table: static entry memory and dynamic entry memory, one read port
// with registered data; per-entry valid bits give the dynamic reset values
// depends on esa_pkg

module esa_task_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  esa_pkg::tm_ctrl_type  ctrl,
   input  esa_pkg::task_cfg_type cfg_wdata,
   input  esa_pkg::task_dyn_type dyn_wdata,
   output esa_pkg::task_cfg_type rd_cfg,
   output esa_pkg::task_dyn_type rd_dyn
);
   import esa_pkg::*;

   task_cfg_type cfg_mem [MAX_TASKS];
   task_dyn_type dyn_mem [MAX_TASKS];

   logic [MAX_TASKS-1:0] dyn_valid_ff;
   logic [MAX_TASKS-1:0] dyn_valid_in;

   task_cfg_type rd_cfg_ff;
   task_dyn_type rd_dyn_ff;
   logic         rd_valid_ff;

   always_comb begin
      dyn_valid_in = dyn_valid_ff;
      if (ctrl.dyn_we) begin
         dyn_valid_in[ctrl.dyn_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dyn_valid_ff <= '0;
      end else begin
         dyn_valid_ff <= dyn_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cfg_we) begin
         cfg_mem[ctrl.cfg_addr] <= cfg_wdata;
      end
      if (ctrl.dyn_we) begin
         dyn_mem[ctrl.dyn_addr] <= dyn_wdata;
      end
      rd_cfg_ff   <= cfg_mem[ctrl.rd_addr];
      rd_dyn_ff   <= dyn_mem[ctrl.rd_addr];
      rd_valid_ff <= dyn_valid_ff[ctrl.rd_addr];
   end

   // never-written entries read as no work and release at time zero
   always_comb begin
      rd_cfg              = rd_cfg_ff;
      rd_dyn.abs_deadline = rd_dyn_ff.abs_deadline;
      rd_dyn.remaining    = rd_valid_ff ? rd_dyn_ff.remaining : '0;
      rd_dyn.next_release = rd_valid_ff ? rd_dyn_ff.next_release : '0;
   end

endmodule
